// File: src/b64enc_pkg.sv
package b64enc_pkg;

   localparam int QueueDepth = 2;
   localparam int SlotCount  = 4;

   localparam logic [7:0] PadChar = 8'h3d;

   // leftover bit counts held between bytes
   localparam logic [2:0] LeftNone = 3'd0;
   localparam logic [2:0] LeftTwo  = 3'd2;
   localparam logic [2:0] LeftFour = 3'd4;

   // One byte's worth of output characters, carried from the front to the back.
   typedef struct packed {
      logic [SlotCount-1:0][5:0] index;
      logic [SlotCount-1:0]      pad;
      logic [1:0]                last_slot;
      logic                      message_end;
   } job_type;

   function automatic logic [7:0] sym_to_ascii(input logic [5:0] sym);
      logic [7:0] wide;
      wide = {2'b00, sym};
      if (sym < 6'd26) begin
         return 8'(8'd65 + wide);
      end else if (sym < 6'd52) begin
         return 8'(8'd71 + wide);
      end else if (sym < 6'd62) begin
         return 8'(wide - 8'd4);
      end else if (sym == 6'd62) begin
         return 8'h2b;
      end else begin
         return 8'h2f;
      end
   endfunction

endpackage

// File: src/b64enc_front.sv
module b64enc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,
   input  logic                req_tlast,
   output logic                job_valid,
   input  logic                job_ready,
   output b64enc_pkg::job_type job
);
   import b64enc_pkg::*;

   logic [3:0] leftover_bits_ff, leftover_bits_in;
   logic [2:0] leftover_count_ff, leftover_count_in;
   logic [1:0] chars_mod_four_ff, chars_mod_four_in;

   logic       accept;
   logic [5:0] sym0, sym1, flush_sym;
   logic [1:0] nsym;
   logic [3:0] new_bits;
   logic [2:0] new_count;
   logic       flush;
   logic [1:0] mod_data, mod_flush, pads;
   logic [2:0] total;

   assign req_tready = job_ready;
   assign job_valid  = req_tvalid;
   assign accept     = req_tvalid && job_ready;

   always_comb begin
      unique case (leftover_count_ff)
         LeftNone: begin
            sym0      = req_tdata[7:2];
            sym1      = 6'd0;
            nsym      = 2'd1;
            new_bits  = {2'b00, req_tdata[1:0]};
            new_count = LeftTwo;
         end
         LeftTwo: begin
            sym0      = {leftover_bits_ff[1:0], req_tdata[7:4]};
            sym1      = 6'd0;
            nsym      = 2'd1;
            new_bits  = req_tdata[3:0];
            new_count = LeftFour;
         end
         default: begin
            sym0      = {leftover_bits_ff, req_tdata[7:6]};
            sym1      = req_tdata[5:0];
            nsym      = 2'd2;
            new_bits  = 4'd0;
            new_count = LeftNone;
         end
      endcase
   end

   // pad the remaining bits with zeros on the right
   assign flush_sym = (new_count == LeftTwo) ? {new_bits[1:0], 4'd0} : {new_bits, 2'd0};
   assign flush     = req_tlast && (new_count != LeftNone);
   assign mod_data  = 2'(chars_mod_four_ff + nsym);
   assign mod_flush = 2'(mod_data + {1'b0, flush});
   assign pads      = req_tlast ? 2'(2'd0 - mod_flush) : 2'd0;
   assign total     = 3'({1'b0, nsym} + {2'b00, flush} + {1'b0, pads});

   always_comb begin
      job.index[0]    = sym0;
      job.index[1]    = (nsym == 2'd2) ? sym1 : flush_sym;
      job.index[2]    = 6'd0;
      job.index[3]    = 6'd0;
      job.pad[0]      = 1'b0;
      job.pad[1]      = (nsym != 2'd2) && !flush;
      job.pad[2]      = 1'b1;
      job.pad[3]      = 1'b1;
      job.last_slot   = 2'(total - 3'd1);
      job.message_end = req_tlast;
   end

   always_comb begin
      leftover_bits_in  = leftover_bits_ff;
      leftover_count_in = leftover_count_ff;
      chars_mod_four_in = chars_mod_four_ff;
      if (accept) begin
         if (req_tlast) begin
            leftover_bits_in  = 4'd0;
            leftover_count_in = LeftNone;
            chars_mod_four_in = 2'd0;
         end else begin
            leftover_bits_in  = new_bits;
            leftover_count_in = new_count;
            chars_mod_four_in = mod_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leftover_bits_ff  <= 4'd0;
         leftover_count_ff <= LeftNone;
         chars_mod_four_ff <= 2'd0;
      end else begin
         leftover_bits_ff  <= leftover_bits_in;
         leftover_count_ff <= leftover_count_in;
         chars_mod_four_ff <= chars_mod_four_in;
      end
   end

   a_count_legal: assert property (@(posedge clock) disable iff (reset)
      leftover_count_ff == LeftNone || leftover_count_ff == LeftTwo ||
      leftover_count_ff == LeftFour)
      else $error("leftover count out of range");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> leftover_count_ff == LeftNone && chars_mod_four_ff == 2'd0)
      else $error("state not cleared after final byte");

   a_message_whole: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |-> 2'(chars_mod_four_ff + total[1:0]) == 2'd0)
      else $error("message length not a multiple of four");

endmodule

// File: src/b64enc_queue.sv
module b64enc_queue #(
   parameter int DEPTH = b64enc_pkg::QueueDepth
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  b64enc_pkg::job_type in_job,
   output logic                out_valid,
   input  logic                out_ready,
   output b64enc_pkg::job_type out_job
);
   import b64enc_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   job_type         mem_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] fill_ff, fill_in;
   logic            push, pop;

   assign in_ready  = fill_ff != CntW'(DEPTH);
   assign out_valid = fill_ff != '0;
   assign out_job   = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : PtrW'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : PtrW'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         fill_in = CntW'(fill_ff + 1'b1);
      end else if (pop && !push) begin
         fill_in = CntW'(fill_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_job;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CntW'(DEPTH))
      else $error("queue overfilled");

endmodule

// File: src/b64enc_back.sv
module b64enc_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_valid,
   output logic                job_ready,
   input  b64enc_pkg::job_type job,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,
   output logic                rsp_tlast,
   output logic                rsp_tuser
);
   import b64enc_pkg::*;

   logic       valid_ff, valid_in;
   logic [1:0] slot_ff, slot_in;
   logic [7:0] char_ff, char_in;
   logic       run_end_ff, run_end_in;
   logic       msg_end_ff, msg_end_in;
   logic       load, take, slot_last;

   assign load      = !valid_ff || rsp_tready;
   assign take      = load && job_valid;
   assign slot_last = slot_ff == job.last_slot;
   assign job_ready = take && slot_last;

   always_comb begin
      valid_in   = valid_ff;
      slot_in    = slot_ff;
      char_in    = char_ff;
      run_end_in = run_end_ff;
      msg_end_in = msg_end_ff;
      if (load) begin
         valid_in = job_valid;
      end
      if (take) begin
         char_in    = job.pad[slot_ff] ? PadChar : sym_to_ascii(job.index[slot_ff]);
         run_end_in = slot_last;
         msg_end_in = slot_last && job.message_end;
         slot_in    = slot_last ? 2'd0 : 2'(slot_ff + 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         slot_ff  <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         slot_ff  <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff    <= char_in;
      run_end_ff <= run_end_in;
      msg_end_ff <= msg_end_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = char_ff;
   assign rsp_tlast  = run_end_ff;
   assign rsp_tuser  = msg_end_ff;

   a_msg_implies_run: assert property (@(posedge clock) disable iff (reset)
      valid_ff && msg_end_ff |-> run_end_ff)
      else $error("message end without run end");

   a_pop_at_run_end: assert property (@(posedge clock) disable iff (reset)
      job_ready |=> valid_ff && run_end_ff)
      else $error("job released before its final character");

endmodule

// File: src/base64_stream_encoder.sv
// Base64 encoder (standard alphabet, '=' padding). Each request carries one
// message byte in req_tdata, with req_tlast set on the final byte of the
// message. Characters come out one per response; rsp_tlast marks the last
// character produced by a byte and rsp_tuser the last character of the
// message, after which the encoder is ready for a new message. A byte
// produces one or two characters, and up to four on the final byte (flush
// plus padding). The output register sends one character per clock while
// rsp_tready is high, and the back end releases a byte's job only with
// its last character. The first character of a byte is registered in the
// job queue and then in the output register. Requests are taken every
// cycle while the job queue between the byte front end and the character
// back end has room.
module base64_stream_encoder #(
   parameter int QUEUE_DEPTH = b64enc_pkg::QueueDepth
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,  // [7:0] data_byte
   input  logic       req_tlast,  // last_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,  // [7:0] out_char
   output logic       rsp_tlast,  // run_end
   output logic       rsp_tuser   // [0] message_end
);
   import b64enc_pkg::*;

   job_type front_job, back_job;
   logic    front_valid, front_ready, back_valid, back_ready;

   b64enc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .job_valid  (front_valid),
      .job_ready  (front_ready),
      .job        (front_job)
   );

   b64enc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_job    (front_job),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_job   (back_job)
   );

   b64enc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (back_valid),
      .job_ready  (back_ready),
      .job        (back_job),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import b64enc_pkg::*;

   localparam int unsigned CycleLimit = 200000;
   localparam int unsigned HoldCycles = 300;
   localparam int unsigned DrainCycles = 20;
   localparam logic [8*64-1:0] Alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef struct {
      logic [7:0] code;
      logic       run_end;
      logic       message_end;
   } char_type;

   typedef struct {
      logic [7:0] data;
      logic       last;
      string      typed;
   } row_type;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;   // [7:0] data_byte
   logic       req_tlast;   // last_byte
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;   // [7:0] out_char
   logic       rsp_tlast;   // run_end
   logic       rsp_tuser;   // [0] message_end

   // encoder state as the bytes go in
   logic [3:0] carry_bits;
   logic [2:0] carry_count;
   logic [1:0] char_phase;

   char_type encoded[$];
   char_type awaited_chars[$];
   row_type  directed[$];

   int unsigned send_pct;
   int unsigned recv_pct;
   int unsigned hold_requests;
   int unsigned mismatches;
   int unsigned bytes_sent;
   int unsigned messages_sent;
   int unsigned chars_checked;
   int unsigned cycle_count;

   base64_stream_encoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CycleLimit) begin
         $display("FAIL base64_stream_encoder");
         $finish;
      end
   end

   function automatic void push_char(input logic [7:0] code);
      char_type c;
      c.code = code;
      c.run_end = 1'b0;
      c.message_end = 1'b0;
      encoded.insert(encoded.size(), c);
      char_phase = char_phase + 2'd1;
   endfunction

   function automatic void add_row(input logic [7:0] d, input logic l, input string typed);
      row_type r;
      r.data = d;
      r.last = l;
      r.typed = typed;
      directed.insert(directed.size(), r);
   endfunction

   // Work out the characters one byte causes; they land in encoded.
   task automatic encode_byte(input logic [7:0] b, input logic l);
      logic [11:0] acc;
      int unsigned n;
      int unsigned sym;
      encoded.delete();
      n = carry_count;
      acc = {carry_bits, b} & ((12'd1 << (n + 8)) - 12'd1);
      n += 8;
      while (n >= 6) begin
         sym = (acc >> (n - 6)) & 12'h3f;
         push_char(Alphabet[8*(63-sym) +: 8]);
         n -= 6;
      end
      carry_bits = 4'(acc & ((12'd1 << n) - 12'd1));
      carry_count = 3'(n);
      if (l) begin
         if (n > 0) begin
            sym = 6'({2'b00, carry_bits} << (6 - n));
            push_char(Alphabet[8*(63-sym) +: 8]);
         end
         while (char_phase != 2'd0 && encoded.size() < 4) begin
            push_char(PadChar);
         end
         encoded[encoded.size()-1].message_end = 1'b1;
         carry_bits = '0;
         carry_count = LeftNone;
         char_phase = '0;
      end
      encoded[encoded.size()-1].run_end = 1'b1;
   endtask

   // Offer one request; called at a falling edge, returns at a falling edge.
   task automatic send_byte(input logic [7:0] b, input logic l, input string typed = "");
      char_type c;
      while ($urandom_range(99) < send_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = b;
      req_tlast = l;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      encode_byte(b, l);
      if (typed.len() == 0) begin
         foreach (encoded[i]) awaited_chars.insert(awaited_chars.size(), encoded[i]);
      end else begin
         for (int i = 0; i < typed.len(); i++) begin
            c.code = typed[i];
            c.run_end = (i == typed.len() - 1);
            c.message_end = c.run_end && l;
            awaited_chars.insert(awaited_chars.size(), c);
         end
      end
      bytes_sent++;
      if (l) messages_sent++;
      @(negedge clock);
   endtask

   task automatic send_message(input int unsigned len);
      for (int unsigned i = 0; i < len; i++) begin
         send_byte(8'($urandom_range(255)), i == len - 1);
      end
   endtask

   initial begin : drive_ready
      int unsigned hold_left;
      int unsigned holds_served;
      hold_left = 0;
      holds_served = 0;
      forever begin
         @(negedge clock);
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left = HoldCycles;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_pct);
         end
      end
   end

   always @(posedge clock) begin : check_chars
      char_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_chars.size() == 0) begin
            $error("out_char: expected nothing, got 0x%02h", rsp_tdata);
            mismatches++;
         end else begin
            want = awaited_chars.pop_front();
            chars_checked++;
            if (rsp_tdata !== want.code) begin
               $error("out_char: expected 0x%02h, got 0x%02h", want.code, rsp_tdata);
               mismatches++;
            end
            if (rsp_tlast !== want.run_end) begin
               $error("run_end: expected %0b, got %0b", want.run_end, rsp_tlast);
               mismatches++;
            end
            if (rsp_tuser !== want.message_end) begin
               $error("message_end: expected %0b, got %0b", want.message_end, rsp_tuser);
               mismatches++;
            end
         end
      end
   end

   initial begin : run_test
      int unsigned send_pcts[4];
      int unsigned recv_pcts[4];
      int unsigned phase_start;
      send_pcts = '{0, 63, 0, 24};
      recv_pcts = '{0, 0, 63, 24};
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      send_pct = 0;
      recv_pct = 0;
      hold_requests = 0;
      carry_bits = '0;
      carry_count = LeftNone;
      char_phase = '0;

      // one-byte messages, the classic three-letter word, and padding of each length
      add_row(8'h00, 1'b1, "AA==");
      add_row(8'hff, 1'b1, "/w==");
      add_row(8'h4d, 1'b0, "T");
      add_row(8'h61, 1'b0, "W");
      add_row(8'h6e, 1'b1, "Fu");
      add_row(8'h4d, 1'b0, "T");
      add_row(8'h61, 1'b1, "WE=");
      add_row(8'hff, 1'b0, "");
      add_row(8'hff, 1'b0, "");
      add_row(8'hff, 1'b1, "");
      // four bytes: the final one yields a symbol, the flush and two pads
      add_row(8'h00, 1'b0, "");
      add_row(8'h00, 1'b0, "");
      add_row(8'h00, 1'b0, "");
      add_row(8'h00, 1'b1, "");
      add_row(8'hfb, 1'b0, "");
      add_row(8'hef, 1'b1, "");
      add_row(8'h80, 1'b0, "");
      add_row(8'h01, 1'b0, "");
      add_row(8'h7f, 1'b0, "");
      add_row(8'hfe, 1'b0, "");
      add_row(8'h55, 1'b0, "");
      add_row(8'haa, 1'b1, "");

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) send_byte(directed[i].data, directed[i].last, directed[i].typed);

      for (int p = 0; p < 4; p++) begin
         send_pct = send_pcts[p];
         recv_pct = recv_pcts[p];
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < 16) begin
            send_message(($urandom_range(9) == 0) ? $urandom_range(10, 20)
                                                  : $urandom_range(1, 6));
         end
      end

      // hold the output back while requests keep coming, so the queue fills
      send_pct = 0;
      recv_pct = 0;
      hold_requests++;
      send_message(16);
      req_tvalid = 1'b0;

      while (awaited_chars.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("Encoded %0d bytes in %0d messages, %0d characters checked,",
               bytes_sent, messages_sent, chars_checked);
      $display("under four idle mixes and one %0d-cycle output hold-off.", HoldCycles);
      if (mismatches == 0) begin
         $display("PASS base64_stream_encoder");
      end else begin
         $display("FAIL base64_stream_encoder");
      end
      $finish;
   end

endmodule

// File: sim.f
src/b64enc_pkg.sv
src/b64enc_front.sv
src/b64enc_queue.sv
src/b64enc_back.sv
src/base64_stream_encoder.sv
test/testbench.sv
